// File: hdl/bdc_pkg.sv
package bdc_pkg;

  localparam int N_BTN       = 4;
  localparam int CODE_LENGTH = 12;
  localparam int STORE_DEPTH = 12;
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
  localparam int CODE_W      = 3;
  localparam int WORD_W      = CODE_W * STORE_DEPTH;
  localparam int SLOTS       = N_BTN + 1;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;

  localparam int BTN_RED    = 0;
  localparam int BTN_YELLOW = 1;
  localparam int BTN_GREEN  = 2;
  localparam int BTN_BLUE   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 1'b1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd5000;

  // Digit appended for each button in code-entry mode, in button order.
  localparam logic [CODE_W-1:0] BTN_CODE [N_BTN] = '{3'd1, 3'd3, 3'd4, 3'd2};

  typedef enum logic [2:0] {
    EV_RED       = 3'd0,
    EV_YELLOW    = 3'd1,
    EV_GREEN     = 3'd2,
    EV_BLUE      = 3'd3,
    EV_CODE_DONE = 3'd4,
    EV_ENTRY     = 3'd5
  } event_t;

  typedef struct packed {
    logic [SLOTS-1:0]         mask;
    event_t [SLOTS-1:0]       ev;
    logic [WORD_W-1:0]        word;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } push_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

// File: hdl/bdc_front.sv
module bdc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [bdc_pkg::TIME_W-1:0] now_ms,
  input  logic [bdc_pkg::N_BTN-1:0]  levels,
  input  logic [bdc_pkg::CFG_W-1:0]  settle_ms,
  input  logic [bdc_pkg::CFG_W-1:0]  hold_ms,
  output logic                       busy,
  output bdc_pkg::push_t             push
);
  import bdc_pkg::*;

  logic [N_BTN-1:0]  raw_previous;
  logic [N_BTN-1:0]  stable_level;
  logic [TIME_W-1:0] change_time [N_BTN];
  logic [TIME_W-1:0] change_time_next [N_BTN];
  logic [TIME_W-1:0] elapsed [N_BTN];
  logic [N_BTN-1:0]  stable_next;

  logic              s1_valid;
  logic [TIME_W-1:0] s1_now;
  logic [N_BTN-1:0]  s1_stab;
  logic [N_BTN-1:0]  s1_old;

  logic [CODE_W-1:0]      code_store [STORE_DEPTH];
  logic [CODE_W-1:0]      code_store_next [STORE_DEPTH];
  logic [STORE_IDX_W-1:0] code_count;
  logic [STORE_IDX_W-1:0] code_count_next;
  logic                   entry_mode;
  logic                   entry_mode_next;
  logic                   hold_valid;
  logic                   hold_valid_next;
  logic [TIME_W-1:0]      hold_start;
  logic [TIME_W-1:0]      hold_start_next;
  logic [TIME_W-1:0]      held;
  logic                   chord;
  logic                   done;
  bundle_t                bundle;

  always_comb begin
    for (int b = 0; b < N_BTN; b++) begin
      change_time_next[b] = (levels[b] != raw_previous[b]) ? now_ms : change_time[b];
      elapsed[b]          = now_ms - change_time_next[b];
      stable_next[b]      = (elapsed[b] >= TIME_W'(settle_ms)) ? levels[b]
                                                               : stable_level[b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_previous <= '1;
      stable_level <= '1;
      for (int b = 0; b < N_BTN; b++) begin
        change_time[b] <= '0;
      end
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      if (in_valid) begin
        raw_previous <= levels;
        stable_level <= stable_next;
        change_time  <= change_time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s1_now  <= now_ms;
      s1_stab <= stable_next;
      s1_old  <= stable_level;
    end
  end

  // Presses are taken in button order; the code count and mode evolve within one sample.
  always_comb begin
    entry_mode_next = entry_mode;
    code_count_next = code_count;
    code_store_next = code_store;
    hold_valid_next = hold_valid;
    hold_start_next = hold_start;
    bundle          = '0;
    done            = 1'b0;
    for (int b = 0; b < N_BTN; b++) begin
      if (!s1_stab[b] && s1_old[b]) begin
        if (entry_mode_next) begin
          code_store_next[code_count_next] = BTN_CODE[b];
          if (code_count_next == STORE_IDX_W'(CODE_LENGTH - 1)) begin
            bundle.mask[b]  = 1'b1;
            bundle.ev[b]    = EV_CODE_DONE;
            done            = 1'b1;
            code_count_next = '0;
            entry_mode_next = 1'b0;
          end else begin
            code_count_next = code_count_next + 1'b1;
          end
        end else begin
          bundle.mask[b] = 1'b1;
          bundle.ev[b]   = event_t'(3'(b));
        end
      end
    end
    if (done) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        bundle.word[CODE_W*i +: CODE_W] = code_store_next[i];
      end
    end
    chord = !s1_stab[BTN_GREEN] && !s1_old[BTN_GREEN] &&
            !s1_stab[BTN_RED] && !s1_old[BTN_RED];
    held  = s1_now - hold_start;
    if (chord) begin
      if (!entry_mode_next && !hold_valid) begin
        hold_start_next = s1_now;
        hold_valid_next = 1'b1;
      end else if (!entry_mode_next && held > TIME_W'(hold_ms)) begin
        entry_mode_next      = 1'b1;
        bundle.mask[SLOTS-1] = 1'b1;
        bundle.ev[SLOTS-1]   = EV_ENTRY;
      end
    end else begin
      hold_valid_next = 1'b0;
      hold_start_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_count <= '0;
      entry_mode <= 1'b0;
      hold_valid <= 1'b0;
      hold_start <= '0;
    end else if (s1_valid) begin
      code_count <= code_count_next;
      entry_mode <= entry_mode_next;
      hold_valid <= hold_valid_next;
      hold_start <= hold_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      code_store <= code_store_next;
    end
  end

  assign busy        = s1_valid;
  assign push.valid  = s1_valid && (|bundle.mask);
  assign push.bundle = bundle;

endmodule

// File: hdl/bdc_queue.sv
module bdc_queue (
  input  logic              clk,
  input  logic              rst,
  input  bdc_pkg::push_t    push,
  input  logic              pop,
  output bdc_pkg::bundle_t  head,
  output bdc_pkg::q_stat_t  stat
);
  import bdc_pkg::*;

  bundle_t           slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push.valid) - QCNT_W'(pop);
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.count = count;

endmodule

// File: hdl/bdc_back.sv
module bdc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  bdc_pkg::bundle_t           head,
  input  bdc_pkg::q_stat_t           stat,
  output logic                       pop,
  input  logic                       out_ready,
  output logic                       out_valid,
  output bdc_pkg::event_t            out_event,
  output logic [bdc_pkg::WORD_W-1:0] out_word,
  output logic                       out_last
);
  import bdc_pkg::*;

  logic              cur_valid;
  bundle_t           cur;
  logic [SLOT_W-1:0] pick;
  logic [SLOTS-1:0]  rest;
  logic              load;
  logic              finish;

  always_comb begin
    pick = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cur.mask[i]) begin
        pick = SLOT_W'(i);
      end
    end
    rest       = cur.mask;
    rest[pick] = 1'b0;
    load       = cur_valid && (!out_valid || out_ready);
    finish     = load && (rest == '0);
    pop        = !stat.empty && (!cur_valid || finish);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end else if (load) begin
      cur.mask <= rest;
    end
    if (load) begin
      out_event <= cur.ev[pick];
      out_word  <= (cur.ev[pick] == EV_CODE_DONE) ? cur.word : '0;
      out_last  <= (rest == '0);
    end
  end

endmodule

// File: hdl/button_debounce_chord_code_entry.sv
// Debouncer for four active-low buttons with chord-started code entry.
// Input stream: one request per pin sample, tdata holds the millisecond
// timestamp and the red, yellow, green and blue levels. Output stream: one
// request per event; tlast marks the final event caused by a sample, and a
// sample that causes no event gives no output at all.
// A sample is accepted every cycle while the result queue has room. The
// front end debounces in one register stage and classifies in the next,
// then writes up to five events as one entry into a four-entry queue. The
// back end sends one event per cycle from the output register while the
// receiver is ready; a sample's events pass the queue and a current-entry
// register on the way, and several events of one sample go out in turn.
// When the receiver stalls, the output register holds its event, the queue
// fills, and tready drops once the queue and the classify stage together
// could no longer take another sample.
// Reset clears the queue, the output, the debounce state (all buttons
// released), the code count, code-entry mode and the chord hold, and loads
// a settle time of 50 ms and a hold time of 5000 ms. The user must write
// registers through cfg_we, cfg_index and cfg_data only while idle; not enforced.
module button_debounce_chord_code_entry (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // now_ms[31:0], red_level[32], yellow_level[33], green_level[34], blue_level[35], zero pad.
  input  logic [bdc_pkg::IN_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // event_res[2:0], code_word[38:3], zero pad.
  output logic [bdc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                          m_tlast
);
  import bdc_pkg::*;

  localparam int OUT_PAD = OUT_DATA_W - WORD_W - 3;

  logic [CFG_W-1:0]  settle_ms;
  logic [CFG_W-1:0]  hold_ms;
  logic              accept;
  logic              front_busy;
  push_t             push;
  bundle_t           head;
  q_stat_t           stat;
  logic              pop;
  event_t            out_event;
  logic [WORD_W-1:0] out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ms <= DEBOUNCE_RESET;
      hold_ms   <= HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: settle_ms <= cfg_data;
        CFG_HOLD:     hold_ms   <= cfg_data;
      endcase
    end
  end

  assign s_tready = (stat.count + QCNT_W'(front_busy)) < QCNT_W'(QDEPTH);
  assign accept   = s_tvalid && s_tready;

  bdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .now_ms    (s_tdata[TIME_W-1:0]),
    .levels    (s_tdata[TIME_W +: N_BTN]),
    .settle_ms (settle_ms),
    .hold_ms   (hold_ms),
    .busy      (front_busy),
    .push      (push)
  );

  bdc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  bdc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_event (out_event),
    .out_word  (out_word),
    .out_last  (m_tlast)
  );

  assign m_tdata = {{OUT_PAD{1'b0}}, out_word, out_event};

endmodule

// File: hdl/bdc_checker.sv
module bdc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bdc_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import bdc_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= EV_ENTRY)
    else $error("undefined event code");

  a_word_only_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != EV_CODE_DONE |-> m_tdata[OUT_DATA_W-1:3] == '0)
    else $error("code word on an event other than code complete");

  a_entry_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == EV_ENTRY |-> m_tlast)
    else $error("entry event not last of its sample");

endmodule

bind button_debounce_chord_code_entry bdc_checker u_bdc_checker (.*);

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bdc_pkg::*;

  typedef struct packed {
    event_t            ev;
    logic [WORD_W-1:0] word;
    logic              last;
  } btn_event_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    logic [TIME_W-1:0]    now;
    logic [N_BTN-1:0]     lvl;
    logic                 typed;
    event_t               first_ev;
    logic [2:0]           n_ev;
  } script_row_t;

  localparam logic [CODE_W-1:0] DIGIT_OF [N_BTN] = '{3'd1, 3'd3, 3'd4, 3'd2};
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;

  // Level bits run red, yellow, green, blue from bit 0; a 0 bit is a pressed button.
  localparam script_row_t SCRIPT [24] = '{
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd0,    4'hF, 1'b1, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd10,   4'hE, 1'b1, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd60,   4'hE, 1'b1, EV_RED,       3'd1},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd130,  4'h0, 1'b1, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd180,  4'h0, 1'b1, EV_YELLOW,    3'd3},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd200,  4'h0, 1'b1, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5200, 4'h0, 1'b1, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5201, 4'h0, 1'b1, EV_ENTRY,     3'd1},
    '{1'b1, CFG_DEBOUNCE, 16'd0, 32'd0,    4'hF, 1'b0, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5300, 4'hA, 1'b1, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5301, 4'h8, 1'b1, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5302, 4'hA, 1'b1, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5303, 4'h0, 1'b0, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5304, 4'hA, 1'b0, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5305, 4'h0, 1'b0, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5306, 4'hA, 1'b0, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5307, 4'h0, 1'b0, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5308, 4'hA, 1'b0, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5309, 4'h0, 1'b0, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5310, 4'hA, 1'b0, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5311, 4'h0, 1'b0, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5312, 4'hA, 1'b0, EV_RED,       3'd0},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5313, 4'h0, 1'b1, EV_CODE_DONE, 3'd3},
    '{1'b0, CFG_DEBOUNCE, 16'd0, 32'd5400, 4'hF, 1'b1, EV_RED,       3'd0}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  btn_event_t        pending_events [$];
  int                errors = 0;
  int                cycles = 0;
  int                tx_idle_pct = 32;
  int                rx_idle_pct = 60;
  int                rx_hold_cycles = 0;
  logic [TIME_W-1:0] stamp;
  logic [N_BTN-1:0]  target;

  logic [CFG_W-1:0]  dbn_ms;
  logic [CFG_W-1:0]  hold_lim;
  logic [N_BTN-1:0]  raw_prev;
  logic [N_BTN-1:0]  stab_lvl;
  logic [TIME_W-1:0] chg_t [N_BTN];
  logic [CODE_W-1:0] digits [STORE_DEPTH];
  logic [3:0]        digit_cnt;
  logic              entry_on;
  logic [TIME_W-1:0] hold_t;
  logic              hold_on;

  button_debounce_chord_code_entry u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void debounce_sample(input logic [TIME_W-1:0] now,
                                          input logic [N_BTN-1:0] lvl,
                                          output int n_ev, output event_t first_ev);
    logic [N_BTN-1:0]  old_lvl;
    logic [N_BTN-1:0]  new_lvl;
    logic [TIME_W-1:0] held;
    logic [WORD_W-1:0] word_acc;
    btn_event_t        found [$];
    btn_event_t        rec;
    for (int b = 0; b < N_BTN; b++) begin
      if (lvl[b] != raw_prev[b]) begin
        chg_t[b] = now;
      end
      raw_prev[b] = lvl[b];
      old_lvl[b] = stab_lvl[b];
      held = now - chg_t[b];
      new_lvl[b] = (held >= {16'd0, dbn_ms}) ? lvl[b] : old_lvl[b];
    end
    for (int b = 0; b < N_BTN; b++) begin
      if (!new_lvl[b] && old_lvl[b]) begin
        if (entry_on) begin
          if (digit_cnt < STORE_DEPTH) begin
            digits[digit_cnt] = DIGIT_OF[b];
          end
          digit_cnt = digit_cnt + 4'd1;
          if (digit_cnt >= CODE_LENGTH) begin
            word_acc = '0;
            for (int i = 0; i < CODE_LENGTH; i++) begin
              word_acc = word_acc | (WORD_W'(digits[i]) << (CODE_W * i));
            end
            rec = '0;
            rec.ev = EV_CODE_DONE;
            rec.word = word_acc;
            found.push_back(rec);
            digit_cnt = '0;
            entry_on = 1'b0;
          end
        end else begin
          rec = '0;
          rec.ev = event_t'(3'(b));
          found.push_back(rec);
        end
      end
    end
    if (!new_lvl[BTN_GREEN] && !old_lvl[BTN_GREEN] && !new_lvl[BTN_RED] && !old_lvl[BTN_RED])
    begin
      held = now - hold_t;
      if (!entry_on && !hold_on) begin
        hold_t = now;
        hold_on = 1'b1;
      end else if (!entry_on && held > {16'd0, hold_lim}) begin
        entry_on = 1'b1;
        rec = '0;
        rec.ev = EV_ENTRY;
        found.push_back(rec);
      end
    end else begin
      hold_on = 1'b0;
      hold_t = '0;
    end
    stab_lvl = new_lvl;
    n_ev = found.size();
    first_ev = EV_RED;
    if (n_ev > 0) begin
      found[n_ev-1].last = 1'b1;
      first_ev = found[0].ev;
    end
    foreach (found[i]) begin
      pending_events.push_back(found[i]);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic send_sample(input logic [TIME_W-1:0] now, input logic [N_BTN-1:0] lvl,
                             output int n_ev, output event_t first_ev);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, lvl, now};
    do @(posedge clk); while (!s_tready);
    debounce_sample(now, lvl, n_ev, first_ev);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEBOUNCE) begin
      dbn_ms = val;
    end else begin
      hold_lim = val;
    end
  endtask

  task automatic run_segment(input logic [CFG_W-1:0] dbn, input logic [CFG_W-1:0] hold,
                             input int tx_pct, input int rx_pct, input int stall_len,
                             input bit near_wrap, input int n_items);
    logic [TIME_W-1:0] dt;
    logic [N_BTN-1:0]  lvl;
    int                n_ev;
    event_t            first_ev;
    wait_drain();
    write_reg(CFG_DEBOUNCE, dbn);
    write_reg(CFG_HOLD, hold);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    rx_hold_cycles = stall_len;
    if (near_wrap) begin
      stamp = 32'hFFFF_FFF0;
    end
    // While the receiver holds off, alternating two-button presses give nearly
    // every sample an event so that the block fills up.
    if (stall_len > 0) begin
      target = 4'h5;
    end
    for (int k = 0; k < n_items; k++) begin
      if (stall_len > 0) begin
        target = ~target;
      end else if ($urandom_range(99) < 35) begin
        if (entry_on) begin
          target = (target == 4'hF) ? 4'($urandom_range(0, 14)) : 4'hF;
        end else begin
          case ($urandom_range(9))
            0, 1, 2, 3, 4: target = 4'hA;
            5, 6:          target = 4'hF;
            default:       target = 4'($urandom_range(0, 15));
          endcase
        end
      end
      case ($urandom_range(9))
        0, 1, 2, 3: dt = {16'd0, dbn_ms} + $urandom_range(0, 3);
        4, 5:       dt = $urandom_range(0, dbn_ms);
        6:          dt = '0;
        7:          dt = {16'd0, hold_lim} + $urandom_range(0, 2);
        8:          dt = {16'd0, hold_lim} - $urandom_range(0, 1);
        default:    dt = $urandom;
      endcase
      lvl = target;
      if ($urandom_range(99) < 12) begin
        lvl[$urandom_range(N_BTN - 1)] ^= 1'b1;
      end
      stamp = stamp + dt;
      send_sample(stamp, lvl, n_ev, first_ev);
    end
  endtask

  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      m_tready <= 1'b0;
      rx_hold_cycles--;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    btn_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        flag_mismatch("event with none pending", 64'(m_tdata), 64'd0);
      end else begin
        want = pending_events.pop_front();
        if (m_tdata[2:0] != want.ev) begin
          flag_mismatch("event_res", 64'(m_tdata[2:0]), 64'(want.ev));
        end
        if (m_tdata[3 +: WORD_W] != want.word) begin
          flag_mismatch("code_word", 64'(m_tdata[3 +: WORD_W]), 64'(want.word));
        end
        if (m_tlast != want.last) begin
          flag_mismatch("tlast", 64'(m_tlast), 64'(want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int     n_ev;
    event_t first_ev;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    dbn_ms = DEBOUNCE_RESET;
    hold_lim = HOLD_RESET;
    raw_prev = '1;
    stab_lvl = '1;
    foreach (chg_t[b]) chg_t[b] = '0;
    foreach (digits[i]) digits[i] = '0;
    digit_cnt = '0;
    entry_on = 1'b0;
    hold_t = '0;
    hold_on = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].is_cfg) begin
        wait_drain();
        write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_val);
      end else begin
        send_sample(SCRIPT[i].now, SCRIPT[i].lvl, n_ev, first_ev);
        if (SCRIPT[i].typed && n_ev != SCRIPT[i].n_ev) begin
          flag_mismatch("event count of a scripted sample", 64'(n_ev), 64'(SCRIPT[i].n_ev));
        end
        if (SCRIPT[i].typed && n_ev > 0 && first_ev != SCRIPT[i].first_ev) begin
          flag_mismatch("first event of a scripted sample", 64'(first_ev),
                        64'(SCRIPT[i].first_ev));
        end
      end
    end
    stamp = 32'd5400;
    target = 4'hF;

    run_segment(16'd0, 16'd0, 32, 60, 0, 1'b0, 20);
    run_segment(16'hFFFF, 16'hFFFF, 32, 60, 0, 1'b0, 20);
    run_segment(16'd1, 16'd1, 60, 32, 0, 1'b1, 20);
    run_segment(16'($urandom_range(2, 200)), 16'($urandom_range(200, 3000)),
                60, 32, 0, 1'b0, 20);
    run_segment(16'd0, HOLD_RESET, 0, 0, 300, 1'b0, 20);
    run_segment(16'd0, 16'hFFFF, 0, 0, 0, 1'b0, 20);
    wait_drain();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
